>>> hw/rtl/pfpw_pkg.sv
// shared types and constants for the page framebuffer pixel writer
// no dependencies; imported by the controller, the datapath and the top level

package pfpw_pkg;

   // stream payload widths
   localparam int REQ_TDATA_W = 16;   // x[6:0], y[12:7], color[13], zero fill
   localparam int RSP_TDATA_W = 8;    // panel_byte
   localparam int RSP_TUSER_W = 2;    // is_data[0], pixel[1]
   localparam int X_W         = 7;
   localparam int Y_W         = 6;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPDATE_ENABLE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLIP_180      = 1'b1;

   // panel command bytes
   localparam logic [7:0] PAGE_CMD     = 8'hB0;
   localparam logic [7:0] COL_HIGH_CMD = 8'h10;
   localparam logic [7:0] NIBBLE_MASK  = 8'h0F;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MODIFY,
      ST_EMIT
   } ctl_state_type;

   typedef enum logic [1:0] {
      OUT_PAGE,
      OUT_COL_LO,
      OUT_COL_HI,
      OUT_DATA
   } out_kind_type;

   typedef struct packed {
      logic         in_ready;
      logic         clear_wr;
      logic         mem_wr;
      logic         load_rsp;
      logic         rsp_read;
      out_kind_type rsp_kind;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic mode;
      logic ok;
      logic update_enable;
      logic out_free;
   } ctl_status_type;

endpackage

>>> hw/rtl/pfpw_ctrl.sv
// controller state machine for the page framebuffer pixel writer
// depends on pfpw_pkg; drives commands into pfpw_datapath

module pfpw_ctrl import pfpw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  ctl_status_type st,
   output ctl_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;
   out_kind_type  kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         kind_ff  <= OUT_PAGE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (st.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_READ;
         end
         ST_READ: begin
            if (!st.mode && !st.ok) state_in = ST_IDLE;
            else                    state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (st.mode) begin
               if (st.out_free) state_in = ST_IDLE;
            end else if (st.update_enable) begin
               state_in = ST_EMIT;
               kind_in  = OUT_PAGE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (st.out_free) begin
               case (kind_ff)
                  OUT_PAGE:   kind_in = OUT_COL_LO;
                  OUT_COL_LO: kind_in = OUT_COL_HI;
                  OUT_COL_HI: kind_in = OUT_DATA;
                  OUT_DATA:   state_in = ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.rsp_kind = kind_ff;
      case (state_ff)
         ST_CLEAR:  cmd.clear_wr = 1'b1;
         ST_IDLE:   cmd.in_ready = 1'b1;
         ST_READ:   ;
         ST_MODIFY: begin
            if (st.mode) begin
               cmd.load_rsp = st.out_free;
               cmd.rsp_read = 1'b1;
            end else begin
               cmd.mem_wr = 1'b1;
            end
         end
         ST_EMIT:   cmd.load_rsp = st.out_free;
         default:   ;
      endcase
   end

endmodule

>>> hw/rtl/pfpw_datapath.sv
// datapath for the page framebuffer pixel writer: config registers, address
// mapping, frame store and result register; depends on pfpw_pkg

module pfpw_datapath import pfpw_pkg::*; #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctl_cmd_type            cmd,
   output ctl_status_type         st,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   output logic                   rsp_tlast
);

   localparam int DEPTH  = PAGES * COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam logic [8:0]        COLS_L  = 9'(COLUMNS);
   localparam logic [4:0]        PAGES_L = 5'(PAGES);
   localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(DEPTH - 1);

   // configuration
   logic update_enable_ff, update_enable_in;
   logic flip_ff, flip_in;

   always_comb begin
      update_enable_in = update_enable_ff;
      flip_in          = flip_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_UPDATE_ENABLE: update_enable_in = csr_wdata[0];
            CSR_FLIP_180:      flip_in          = csr_wdata[0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         update_enable_ff <= 1'b1;
         flip_ff          <= 1'b0;
      end else begin
         update_enable_ff <= update_enable_in;
         flip_ff          <= flip_in;
      end
   end

   // item capture and pixel mapping
   logic              accept;
   logic [8:0]        x9;
   logic [4:0]        p5;
   logic [2:0]        b3;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [2:0]        bit_ff, bit_in;
   logic              ok_ff, ok_in;
   logic              mode_ff, color_ff;

   assign accept = cmd.in_ready && req_tvalid;
   assign x9     = 9'(req_tdata[X_W-1:0]);
   assign p5     = 5'(req_tdata[X_W+Y_W-1:X_W+3]);
   assign b3     = req_tdata[X_W+2:X_W];

   always_comb begin
      ok_in = (x9 < COLS_L) && (p5 < PAGES_L);
      if (flip_ff) begin
         col_in  = COL_W'(COLS_L - 9'd1 - x9);
         page_in = PAGE_W'(PAGES_L - 5'd1 - p5);
         bit_in  = 3'd7 - b3;
      end else begin
         col_in  = COL_W'(x9);
         page_in = PAGE_W'(p5);
         bit_in  = b3;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff   <= col_in;
         page_ff  <= page_in;
         bit_ff   <= bit_in;
         ok_ff    <= ok_in;
         mode_ff  <= req_tuser;
         color_ff <= req_tdata[X_W+Y_W];
      end
   end

   // frame store with clearing pass after reset
   logic [7:0]        mem [DEPTH];
   logic [7:0]        rdata_ff;
   logic [7:0]        new_byte, new_byte_ff;
   logic [ADDR_W-1:0] addr;
   logic [ADDR_W-1:0] clr_ff;
   logic [ADDR_W-1:0] waddr;
   logic [7:0]        wdata;
   logic              we;

   assign addr = ADDR_W'(ADDR_W'(page_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff));

   always_comb begin
      new_byte = rdata_ff;
      new_byte[bit_ff] = color_ff;
   end

   assign we    = cmd.clear_wr || cmd.mem_wr;
   assign waddr = cmd.clear_wr ? clr_ff : addr;
   assign wdata = cmd.clear_wr ? 8'h00 : new_byte;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset)             clr_ff <= '0;
      else if (cmd.clear_wr) clr_ff <= clr_ff + ADDR_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) new_byte_ff <= new_byte;
   end

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_is_data_ff, rsp_is_data_in;
   logic       rsp_pixel_ff, rsp_pixel_in;
   logic       rsp_last_ff, rsp_last_in;
   logic [7:0] page8, col8;

   assign page8 = 8'(page_ff);
   assign col8  = 8'(col_ff);

   always_comb begin
      rsp_byte_in    = 8'h00;
      rsp_is_data_in = 1'b0;
      rsp_pixel_in   = 1'b0;
      rsp_last_in    = 1'b0;
      if (cmd.rsp_read) begin
         rsp_pixel_in = ok_ff && rdata_ff[bit_ff];
         rsp_last_in  = 1'b1;
      end else begin
         case (cmd.rsp_kind)
            OUT_PAGE:   rsp_byte_in = PAGE_CMD + page8;
            OUT_COL_LO: rsp_byte_in = col8 & NIBBLE_MASK;
            OUT_COL_HI: rsp_byte_in = COL_HIGH_CMD + ((col8 >> 4) & NIBBLE_MASK);
            OUT_DATA: begin
               rsp_byte_in    = new_byte_ff;
               rsp_is_data_in = 1'b1;
               rsp_last_in    = 1'b1;
            end
            default:    rsp_byte_in = 8'h00;
         endcase
      end
   end

   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_byte_ff    <= rsp_byte_in;
         rsp_is_data_ff <= rsp_is_data_in;
         rsp_pixel_ff   <= rsp_pixel_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = {rsp_pixel_ff, rsp_is_data_ff};
   assign rsp_tlast  = rsp_last_ff;

   // status to the controller
   assign st.clear_done    = (clr_ff == LAST_A);
   assign st.mode          = mode_ff;
   assign st.ok            = ok_ff;
   assign st.update_enable = update_enable_ff;
   assign st.out_free      = !rsp_valid_ff || rsp_tready;

endmodule

>>> hw/rtl/page_framebuffer_pixel_writer.sv
// top level of the page framebuffer pixel writer
// depends on pfpw_pkg, pfpw_ctrl and pfpw_datapath

// Pixel writer for a monochrome page-mode panel of PAGES pages by COLUMNS
// column bytes (128x64 by default). Each request transfer writes or reads one
// pixel; a write does a read-modify-write of its store byte and, with
// update_enable set, sends four bytes to the panel: page command, column low
// command, column high command, then the new data byte (tlast on the data
// byte). A read returns one transfer with the pixel in tuser and tlast set.
// Writes off the panel are dropped with no response; reads off the panel
// return pixel 0. flip_180 mirrors page, column and bit for both writes and
// reads. After reset the store is swept to zero, one byte per cycle, over all
// PAGES*COLUMNS bytes while req_tready stays low; configuration writes are
// taken at any time. Sequence: an accepted item moves to ST_READ, where the
// frame store read is registered; a write off the panel then returns to idle.
// Otherwise it moves to ST_MODIFY, where a write does its write-back and a
// read loads its response; with write-through it then moves to ST_EMIT, where
// the four panel bytes leave the response register one per cycle while
// rsp_tready does not hold back a waiting byte. The response register lets
// the next item be accepted while the final byte still waits.

module page_framebuffer_pixel_writer import pfpw_pkg::*; #(
   parameter int COLUMNS = 128,   // 8 to 256
   parameter int PAGES   = 8      // 1 to 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration writes
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,   // 0 update_enable, 1 flip_180
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // x[6:0], y[12:7], color[13]
   input  logic                   req_tuser,   // mode: 0 write, 1 read
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // panel_byte[7:0]
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // is_data[0], pixel[1]
   output logic                   rsp_tlast
);

   ctl_cmd_type    cmd;
   ctl_status_type st;

   // sequencing: clear sweep, accept, store read, write-back, byte emission
   pfpw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .st         (st),
      .cmd        (cmd)
   );

   // mapping, frame store and response register
   pfpw_datapath #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // one item in flight: no acceptance right after a transfer in
   assign req_tready = cmd.in_ready;

   // checks

   // the clearing sweep and a pixel write-back never share the store port
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_wr && cmd.mem_wr))
      else $error("clear sweep and write-back collide");

   // at most one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while an item is in flight");

   // the response register is only reloaded when empty or draining
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_tvalid || rsp_tready))
      else $error("pending response overwritten");

   // a set pixel bit only comes on a read response, which is a lone last transfer
   a_read_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tlast && !rsp_tuser[0] && rsp_tdata == 8'h00))
      else $error("malformed read response");

endmodule
